// ===== rtl/eig2_pkg.sv =====
// ----------------------------------------------------------------------------
// eig2_pkg
// Shared widths, constants and types of the 2x2 symmetric eigen solver.
// ----------------------------------------------------------------------------
package eig2_pkg;

  localparam int unsigned ElemW   = 32;
  localparam int unsigned VecW    = 16;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned EW      = 66;
  localparam int unsigned RootW   = 33;
  localparam int unsigned NormW   = 65;
  localparam int unsigned NRootW  = 33;
  localparam int unsigned Q14One  = 16384;
  localparam int unsigned ThreshW = 32;

  typedef struct packed {
    logic signed [ElemW-1:0] elem_a;
    logic signed [ElemW-1:0] elem_b;
    logic signed [ElemW-1:0] elem_c;
    logic signed [ElemW-1:0] elem_d;
  } tensor_t;

  typedef struct packed {
    logic signed [ElemW-1:0] lambda_major;
    logic signed [ElemW-1:0] lambda_minor;
    logic signed [VecW-1:0]  vec_major_x;
    logic signed [VecW-1:0]  vec_major_y;
    logic signed [VecW-1:0]  vec_minor_x;
    logic signed [VecW-1:0]  vec_minor_y;
    logic                    diag_taken;
    logic                    saturated;
  } eigen_t;

endpackage

// ===== rtl/eig2_if.sv =====
// ----------------------------------------------------------------------------
// eig2_in_if / eig2_out_if
// Valid/ready channels carrying a tensor in and an eigen result out.
// ----------------------------------------------------------------------------
interface eig2_in_if;
  logic              valid;
  logic              ready;
  eig2_pkg::tensor_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface eig2_out_if;
  logic             valid;
  logic             ready;
  eig2_pkg::eigen_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/eigen_2x2_solver_unit.sv =====
// ----------------------------------------------------------------------------
// eigen_2x2_solver_unit
// Pipelined eigen-decomposition of a 2x2 tensor taken as symmetric.
// ----------------------------------------------------------------------------
// One tensor is accepted every cycle while the output side takes results; the
// pipeline holds one product stage, a restoring square root on the
// discriminant (one result bit per stage, 33 stages), a stage to form the
// eigenvalues, a stage for the vector components, squared norms and clipping,
// a second bit-serial square root for each norm (35 stages) and four
// restoring dividers of 15 quotient bits (one bit per stage), then the output
// register. The whole pipeline advances together, so a stall at the output
// freezes every stage and loses nothing. The threshold register is written
// through cfg_we_i/cfg_wdata_i.
module eigen_2x2_solver_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [eig2_pkg::ThreshW-1:0]  cfg_wdata_i,
  eig2_in_if.sink                       in_if,
  eig2_out_if.source                    out_if
);
  import eig2_pkg::*;

  localparam int unsigned DivW  = 15;
  localparam int unsigned NSr1  = RootW;
  localparam int unsigned NSr2  = NRootW + 2;
  localparam int unsigned NDiv  = DivW;
  localparam int unsigned Depth = 1 + NSr1 + 1 + 1 + NSr2 + NDiv + 1;

  logic [ThreshW-1:0] thresh_q;
  logic               adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // valid chain: the pipeline moves as one when the tail is free
  logic [Depth-1:0] vld_q;
  assign adv         = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  // ---------------- stage 0: products --------------------------------------
  typedef struct packed {
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] b;
    logic signed [ElemW-1:0] d;
    logic                    diag;
    logic [EW-1:0]           e;
  } s0_t;

  s0_t s0_q;
  logic signed [ProdW-1:0] prod;
  logic signed [ElemW:0]   amd;
  logic [ElemW:0]          amd_mag;

  always_comb begin
    prod    = ProdW'(in_if.data.elem_b) * ProdW'(in_if.data.elem_c);
    amd     = (ElemW+1)'(in_if.data.elem_a) - (ElemW+1)'(in_if.data.elem_d);
    amd_mag = amd[ElemW] ? (ElemW+1)'(-amd) : amd;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.a    <= in_if.data.elem_a;
      s0_q.b    <= in_if.data.elem_b;
      s0_q.d    <= in_if.data.elem_d;
      s0_q.diag <= prod <= $signed({1'b0, ProdW'(thresh_q)});
      // 4*P reaches 2^64 when both off-diagonal terms are the most negative
      s0_q.e    <= EW'(amd_mag * amd_mag) + {prod[ProdW-2:0], 2'b00};
    end
  end

  // ---------------- square root of discriminant ----------------------------
  typedef struct packed {
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] b;
    logic signed [ElemW-1:0] d;
    logic                    diag;
    logic [EW+1:0]           rem;
    logic [EW-1:0]           val;
    logic [RootW-1:0]        root;
  } sr1_t;

  sr1_t sr1_q [NSr1];

  for (genvar i = 0; i < NSr1; i++) begin : g_sr1
    sr1_t src, nxt;
    logic [EW+1:0] trial, rsh;
    always_comb begin
      if (i == 0) begin
        src      = '0;
        src.a    = s0_q.a;
        src.b    = s0_q.b;
        src.d    = s0_q.d;
        src.diag = s0_q.diag;
        src.val  = s0_q.e;
      end else begin
        src = sr1_q[(i == 0) ? 0 : i-1];
      end
      nxt     = src;
      rsh     = {src.rem[EW-1:0], src.val[EW-1 -: 2]};
      trial   = (EW+2)'({src.root, 2'b01});
      nxt.val = {src.val[EW-3:0], 2'b00};
      if (rsh >= trial) begin
        nxt.rem  = rsh - trial;
        nxt.root = {src.root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = rsh;
        nxt.root = {src.root[RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) sr1_q[i] <= nxt;
    end
  end

  // ---------------- eigenvalues and raw vectors ----------------------------
  typedef struct packed {
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] d;
    logic                    diag;
    logic signed [ElemW+1:0] l1;
    logic signed [ElemW+1:0] l2;
    logic signed [ElemW-1:0] b;
  } ev_t;

  ev_t ev_q;
  sr1_t sr1_last;
  logic signed [ElemW:0]   sum_ad;
  logic signed [ElemW+1:0] h_v, s_v;

  always_comb begin
    sr1_last = sr1_q[NSr1-1];
    sum_ad   = (ElemW+1)'(sr1_last.a) + (ElemW+1)'(sr1_last.d);
    // halve toward zero
    h_v      = (ElemW+2)'($signed(sum_ad + {{ElemW{1'b0}}, sum_ad[ElemW]}) >>> 1);
    s_v      = $signed({1'b0, sr1_last.root[RootW-1:1], 1'b0}) >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ev_q.a    <= sr1_last.a;
      ev_q.d    <= sr1_last.d;
      ev_q.b    <= sr1_last.b;
      ev_q.diag <= sr1_last.diag;
      ev_q.l1   <= h_v + s_v;
      ev_q.l2   <= h_v - s_v;
    end
  end

  // stage: squared norms and clipping
  typedef struct packed {
    logic signed [ElemW-1:0] o1;
    logic signed [ElemW-1:0] o2;
    logic                    diag;
    logic                    sat;
    logic signed [ElemW+2:0] x1;
    logic signed [ElemW+2:0] x2;
    logic signed [ElemW-1:0] y;
    logic [NormW+4:0]        n1;
    logic [NormW+4:0]        n2;
  } nm_t;

  nm_t nm_q;
  logic signed [ElemW+2:0] x1_v, x2_v;
  logic [ElemW+2:0]        x1m, x2m;
  logic [ElemW-1:0]        ym;
  logic                    hi1, lo1, hi2, lo2;

  always_comb begin
    x1_v = (ElemW+3)'(ev_q.l1) - (ElemW+3)'(ev_q.d);
    x2_v = (ElemW+3)'(ev_q.l2) - (ElemW+3)'(ev_q.d);
    x1m  = x1_v[ElemW+2] ? (ElemW+3)'(-x1_v) : x1_v;
    x2m  = x2_v[ElemW+2] ? (ElemW+3)'(-x2_v) : x2_v;
    ym   = ev_q.b[ElemW-1] ? ElemW'(-ev_q.b) : ev_q.b;
    hi1  = ev_q.l1 > (ElemW+2)'($signed(32'sh7fffffff));
    lo1  = ev_q.l1 < -(ElemW+2)'(34'sh80000000);
    hi2  = ev_q.l2 > (ElemW+2)'($signed(32'sh7fffffff));
    lo2  = ev_q.l2 < -(ElemW+2)'(34'sh80000000);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_q.diag <= ev_q.diag;
      nm_q.x1   <= x1_v;
      nm_q.x2   <= x2_v;
      nm_q.y    <= ev_q.b;
      nm_q.n1   <= (NormW+5)'(x1m * x1m) + (NormW+5)'(ym * ym);
      nm_q.n2   <= (NormW+5)'(x2m * x2m) + (NormW+5)'(ym * ym);
      nm_q.sat  <= !ev_q.diag && (hi1 || lo1 || hi2 || lo2);
      if (ev_q.diag) begin
        nm_q.o1 <= ev_q.a;
        nm_q.o2 <= ev_q.d;
      end else begin
        nm_q.o1 <= hi1 ? 32'sh7fffffff : lo1 ? 32'sh80000000 : ev_q.l1[ElemW-1:0];
        nm_q.o2 <= hi2 ? 32'sh7fffffff : lo2 ? 32'sh80000000 : ev_q.l2[ElemW-1:0];
      end
    end
  end

  // ---------------- norm square roots, two lanes ---------------------------
  localparam int unsigned NvW = NormW + 5;
  localparam int unsigned NrW = NRootW + 2;

  typedef struct packed {
    logic signed [ElemW-1:0] o1;
    logic signed [ElemW-1:0] o2;
    logic                    diag;
    logic                    sat;
    logic signed [ElemW+2:0] x1;
    logic signed [ElemW+2:0] x2;
    logic signed [ElemW-1:0] y;
    logic [NvW+1:0]          rem1;
    logic [NvW+1:0]          rem2;
    logic [NvW-1:0]          v1;
    logic [NvW-1:0]          v2;
    logic [NrW-1:0]          r1;
    logic [NrW-1:0]          r2;
  } sr2_t;

  sr2_t sr2_q [NrW];

  for (genvar i = 0; i < NrW; i++) begin : g_sr2
    sr2_t src, nxt;
    logic [NvW+1:0] t1, t2, s1, s2;
    always_comb begin
      if (i == 0) begin
        src      = '0;
        src.o1   = nm_q.o1;
        src.o2   = nm_q.o2;
        src.diag = nm_q.diag;
        src.sat  = nm_q.sat;
        src.x1   = nm_q.x1;
        src.x2   = nm_q.x2;
        src.y    = nm_q.y;
        src.v1   = nm_q.n1;
        src.v2   = nm_q.n2;
      end else begin
        src = sr2_q[(i == 0) ? 0 : i-1];
      end
      nxt    = src;
      s1     = {src.rem1[NvW-1:0], src.v1[NvW-1 -: 2]};
      s2     = {src.rem2[NvW-1:0], src.v2[NvW-1 -: 2]};
      t1     = (NvW+2)'({src.r1, 2'b01});
      t2     = (NvW+2)'({src.r2, 2'b01});
      nxt.v1 = {src.v1[NvW-3:0], 2'b00};
      nxt.v2 = {src.v2[NvW-3:0], 2'b00};
      nxt.rem1 = (s1 >= t1) ? s1 - t1 : s1;
      nxt.rem2 = (s2 >= t2) ? s2 - t2 : s2;
      nxt.r1   = {src.r1[NrW-2:0], s1 >= t1};
      nxt.r2   = {src.r2[NrW-2:0], s2 >= t2};
    end
    always_ff @(posedge clk_i) begin
      if (adv) sr2_q[i] <= nxt;
    end
  end

  // ---------------- dividers: |comp|*16384 / n, 15 quotient bits -----------
  // quotient <= 16384, so 15 bits; restoring, one bit a stage, four lanes
  localparam int unsigned QW = 15;
  localparam int unsigned DnW = NrW + 1;

  typedef struct packed {
    logic signed [ElemW-1:0] o1;
    logic signed [ElemW-1:0] o2;
    logic                    diag;
    logic                    sat;
    logic [3:0]              neg;
    logic [3:0][ElemW+2:0]   num;
    logic [3:0][DnW-1:0]     rem;
    logic [3:0][QW-1:0]      q;
    logic [NrW-1:0]          n1;
    logic [NrW-1:0]          n2;
  } dv_t;

  dv_t dv_q [NDiv];

  for (genvar i = 0; i < NDiv; i++) begin : g_dv
    dv_t src, nxt;
    sr2_t sl;
    logic [DnW-1:0] sh, dn;
    always_comb begin
      sl = sr2_q[NrW-1];
      if (i == 0) begin
        src      = '0;
        src.o1   = sl.o1;
        src.o2   = sl.o2;
        src.diag = sl.diag;
        src.sat  = sl.sat;
        src.n1   = sl.r1;
        src.n2   = sl.r2;
        src.neg  = {sl.y[ElemW-1], sl.x2[ElemW+2], sl.y[ElemW-1], sl.x1[ElemW+2]};
        src.num[0] = sl.x1[ElemW+2] ? (ElemW+3)'(-sl.x1) : sl.x1;
        // magnitude of the most negative y needs all 32 bits unsigned
        src.num[1] = (ElemW+3)'($unsigned(sl.y[ElemW-1] ? -sl.y : sl.y));
        src.num[2] = sl.x2[ElemW+2] ? (ElemW+3)'(-sl.x2) : sl.x2;
        src.num[3] = src.num[1];
        // leading integer part: num*16384/n with num <= n gives q <= 16384;
        // start remainder = num (already < 2n), shift in 14 zero bits
        for (int k = 0; k < 4; k++) src.rem[k] = DnW'(src.num[k]);
      end else begin
        src = dv_q[(i == 0) ? 0 : i-1];
      end
      nxt = src;
      for (int k = 0; k < 4; k++) begin
        dn = DnW'((k < 2) ? src.n1 : src.n2);
        sh = (i == 0) ? src.rem[k] : {src.rem[k][DnW-2:0], 1'b0};
        if (sh >= dn) begin
          nxt.rem[k] = sh - dn;
          nxt.q[k]   = {src.q[k][QW-2:0], 1'b1};
        end else begin
          nxt.rem[k] = sh;
          nxt.q[k]   = {src.q[k][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[i] <= nxt;
    end
  end

  dv_t dl;
  logic signed [VecW-1:0] comp [4];
  always_comb begin
    dl = dv_q[NDiv-1];
    for (int k = 0; k < 4; k++) begin
      comp[k] = dl.neg[k] ? VecW'(-{1'b0, dl.q[k]}) : VecW'({1'b0, dl.q[k]});
    end
  end

  // output register is the last stage: drive the port straight from it
  eigen_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.lambda_major <= dl.o1;
      res_q.lambda_minor <= dl.o2;
      res_q.diag_taken   <= dl.diag;
      res_q.saturated    <= dl.sat;
      if (dl.diag) begin
        res_q.vec_major_x <= VecW'(Q14One);
        res_q.vec_major_y <= '0;
        res_q.vec_minor_x <= '0;
        res_q.vec_minor_y <= VecW'(Q14One);
      end else begin
        res_q.vec_major_x <= comp[0];
        res_q.vec_major_y <= comp[1];
        res_q.vec_minor_x <= comp[2];
        res_q.vec_minor_y <= comp[3];
      end
    end
  end

  assign out_if.valid = vld_q[Depth-1];
  assign out_if.data  = res_q;

  // ---------------- checks --------------------------------------------------
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed under stall");
  a_diag_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.diag_taken |-> !out_if.data.saturated)
    else $error("shortcut result flagged saturated");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with empty tail");

endmodule

// ===== test/eigen_2x2_solver_unit_test.sv =====
// ----------------------------------------------------------------------------
// eigen_2x2_solver_unit_test
// Self-checking bench for the 2x2 symmetric eigen solver. Tensors are driven
// on the input channel and every result is compared with a local predictor.
// The threshold register is stepped through several values, including zero
// and all ones. Both channels idle at random, and one long output hold-off
// fills the pipeline.
// ----------------------------------------------------------------------------
module eigen_2x2_solver_unit_test;
  import eig2_pkg::*;

  localparam int unsigned DrainCycles = 200;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned LongHold    = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [ThreshW-1:0]   cfg_wdata_i;

  eig2_in_if  in_if ();
  eig2_out_if out_if ();

  eigen_2x2_solver_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  bit [ThreshW-1:0] offdiag_limit;
  eigen_t           pending_eigen[$];
  int unsigned      mismatch_cnt;
  int unsigned      tensors_sent;
  int unsigned      results_seen;
  int unsigned      diag_seen;
  int unsigned      sat_seen;
  int unsigned      idle_cycles;
  bit               hold_results;
  bit               no_gaps;
  int unsigned      result_stall;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [35:0] root72(input logic [71:0] v);
    logic [35:0] r;
    logic [35:0] c;
    r = '0;
    for (int i = 35; i >= 0; i--) begin
      c = r | (36'd1 << i);
      if (({36'd0, c} * {36'd0, c}) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [71:0] mag72(input longint v);
    return (v < 0) ? 72'(-v) : 72'(v);
  endfunction

  function automatic longint clip32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void unit_dir(input longint x, input longint y,
                                   output longint ux, output longint uy);
    logic [71:0] xm;
    logic [71:0] ym;
    longint      n;
    xm = mag72(x);
    ym = mag72(y);
    n  = longint'(root72(xm * xm + ym * ym));
    if (n == 0) begin
      ux = Q14One;
      uy = 0;
    end else begin
      // keep the arithmetic signed so the quotient truncates toward zero
      ux = (x * longint'(Q14One)) / n;
      uy = (y * longint'(Q14One)) / n;
    end
  endfunction

  function automatic eigen_t solve_tensor(input tensor_t t);
    longint      a, b, c, d, prod, s, h, l1, l2, vx, vy;
    logic [71:0] dm;
    logic [71:0] disc;
    eigen_t      r;
    bit          sat;
    a = t.elem_a;
    b = t.elem_b;
    c = t.elem_c;
    d = t.elem_d;
    prod = b * c;
    sat = 1'b0;
    if (prod <= longint'(offdiag_limit)) begin
      r.lambda_major = a[31:0];
      r.lambda_minor = d[31:0];
      r.vec_major_x  = VecW'(Q14One);
      r.vec_major_y  = '0;
      r.vec_minor_x  = '0;
      r.vec_minor_y  = VecW'(Q14One);
      r.diag_taken   = 1'b1;
      r.saturated    = 1'b0;
    end else begin
      dm   = mag72(a - d);
      disc = dm * dm + (72'(prod) << 2);
      s    = longint'(root72(disc) >> 1);
      h    = (a + d) / 2;
      l1   = h + s;
      l2   = h - s;
      r.lambda_major = 32'(clip32(l1, sat));
      r.lambda_minor = 32'(clip32(l2, sat));
      unit_dir(l1 - d, b, vx, vy);
      r.vec_major_x = vx[15:0];
      r.vec_major_y = vy[15:0];
      unit_dir(l2 - d, b, vx, vy);
      r.vec_minor_x = vx[15:0];
      r.vec_minor_y = vy[15:0];
      r.diag_taken  = 1'b0;
      r.saturated   = sat;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors and checks
  // --------------------------------------------------------------------------
  task automatic report(input string field, input longint want, input longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      pending_eigen.push_back(solve_tensor(in_if.data));
    end
  end

  always @(posedge clk_i) begin
    eigen_t want;
    eigen_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      results_seen++;
      if (pending_eigen.size() == 0) begin
        $display("%0t: result with no tensor outstanding", $realtime);
        mismatch_cnt++;
      end else begin
        want = pending_eigen.pop_front();
        if (want.diag_taken) diag_seen++;
        if (want.saturated) sat_seen++;
        if (got.lambda_major !== want.lambda_major)
          report("lambda_major", want.lambda_major, got.lambda_major);
        if (got.lambda_minor !== want.lambda_minor)
          report("lambda_minor", want.lambda_minor, got.lambda_minor);
        if (got.vec_major_x !== want.vec_major_x)
          report("vec_major_x", want.vec_major_x, got.vec_major_x);
        if (got.vec_major_y !== want.vec_major_y)
          report("vec_major_y", want.vec_major_y, got.vec_major_y);
        if (got.vec_minor_x !== want.vec_minor_x)
          report("vec_minor_x", want.vec_minor_x, got.vec_minor_x);
        if (got.vec_minor_y !== want.vec_minor_y)
          report("vec_minor_y", want.vec_minor_y, got.vec_minor_y);
        if (got.diag_taken !== want.diag_taken)
          report("diag_taken", want.diag_taken, got.diag_taken);
        if (got.saturated !== want.saturated)
          report("saturated", want.saturated, got.saturated);
      end
    end
  end

  // Random gap: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: hold ready low while the hold-off runs, else stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      result_stall <= 0;
    end else if (hold_results) begin
      out_if.ready <= 1'b0;
    end else if (result_stall > 0) begin
      result_stall <= result_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      n = pick_gap();
      result_stall <= (n > 0) ? n - 1 : 0;
      out_if.ready <= (n == 0);
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $realtime, StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_tensor(input tensor_t t);
    int unsigned n;
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (!in_if.ready);
    tensors_sent++;
    n = pick_gap();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_elems(input int a, input int b, input int c, input int d);
    tensor_t t;
    t.elem_a = a;
    t.elem_b = b;
    t.elem_c = c;
    t.elem_d = d;
    send_tensor(t);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_eigen.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write only with the pipeline empty.
  task automatic set_limit(input bit [ThreshW-1:0] v);
    drain();
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    offdiag_limit  = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_elem();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return int'($urandom());
    if (r < 8) return $signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64;
    return $signed($urandom_range(0, 64)) - 32;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_extremes();
    localparam int Max = 32'h7fffffff;
    localparam int Min = 32'h80000000;
    send_elems(0, 0, 0, 0);
    send_elems(Max, Max, Max, Max);
    send_elems(Min, Min, Min, Min);
    send_elems(Max, Max, Max, Min);
    send_elems(Min, Min, Min, Max);
    send_elems(Max, 0, 5, Min);
    send_elems(Min, -1, 1, Max);
    send_elems(65536, 65536, 65536, 65536);
    send_elems(3 << 16, 1 << 16, 1 << 16, 3 << 16);
    send_elems(-(2 << 16), 7, 9, 5 << 16);
    send_elems(0, 1, 1, 0);
    send_elems(0, -1, -1, 0);
    send_elems(-1, Max, 1, -1);
    send_elems(Max, 1, 1, Max);
    send_elems(Min, 1, 1, Min);
    send_elems(123456, Min, Max, -98765);
  endtask

  task automatic test_limit_edges();
    set_limit(32'd1);
    send_elems(1 << 16, 1, 1, 2 << 16);
    send_elems(1 << 16, 1, 2, 2 << 16);
    send_elems(1 << 16, -1, -1, 2 << 16);
    set_limit(32'hffffffff);
    send_elems(0, 65535, 65537, 0);
    send_elems(0, 65536, 65536, 0);
    send_elems(0, 65537, 65536, 0);
    send_elems(5, 32'h7fffffff, 32'h7fffffff, -5);
    set_limit(32'h0);
  endtask

  task automatic test_random(input int unsigned count);
    tensor_t     t;
    int unsigned mode;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 300 == 0) begin
        mode = $urandom_range(0, 3);
        case (mode)
          0: set_limit(32'h0);
          1: set_limit(32'hffffffff);
          2: set_limit($urandom_range(1, 65536));
          default: set_limit($urandom());
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      t.elem_a = rand_elem();
      t.elem_b = rand_elem();
      t.elem_d = rand_elem();
      // Symmetric tensors are the usual case; keep some skewed ones.
      t.elem_c = ($urandom_range(0, 2) != 0) ? t.elem_b : rand_elem();
      send_tensor(t);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    tensor_t t;
    drain();
    fork
      begin
        hold_results = 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_results = 1'b0;
      end
      for (int i = 0; i < 150; i++) begin
        t.elem_a = rand_elem();
        t.elem_b = rand_elem();
        t.elem_c = t.elem_b;
        t.elem_d = rand_elem();
        send_tensor(t);
      end
    join
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    offdiag_limit = '0;
    hold_results = 1'b0;
    no_gaps      = 1'b0;
    idle_cycles  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_limit_edges();
    test_backpressure();
    test_random(1380);
    drain();

    $display("Covered %0d tensors, %0d results (%0d diagonal, %0d saturated),",
             tensors_sent, results_seen, diag_seen, sat_seen);
    $display("thresholds from zero to all ones and a long output hold-off.");
    if (mismatch_cnt == 0 && pending_eigen.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_eigen.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
